FILE: src/psg_pkg.sv
package psg_pkg;

    // Fixed field widths
    localparam int DRAW_W  = 31;
    localparam int COUNT_W = 7;
    localparam int PICK_W  = 6;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;
    localparam int MAX_ELEMENTS_DEF = 64;

    // Remainder unit: DIV_BITS quotient bits per cycle
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = (DRAW_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIVD_W    = DIV_STEPS * DIV_BITS;

    typedef struct packed {
        logic start;
        logic step;
    } t_div_ctl;

    typedef enum logic [2:0] {
        OP_NOP    = 3'd0,
        OP_ACCEPT = 3'd1,
        OP_INIT   = 3'd2,
        OP_DIV    = 3'd3,
        OP_SEL    = 3'd4,
        OP_WR_POS = 3'd5,
        OP_WR_SEL = 3'd6,
        OP_CLEAR  = 3'd7
    } t_uop;

    typedef enum logic [2:0] {
        C_NONE     = 3'd0,
        C_NO_ITEM  = 3'd1,
        C_RESTART  = 3'd2,
        C_DIV_MORE = 3'd3,
        C_OUT_BUSY = 3'd4,
        C_NOT_LAST = 3'd5,
        C_CLR_MORE = 3'd6,
        C_PEND     = 3'd7
    } t_ucond;

    typedef logic [2:0] t_upc;

    localparam t_upc P_IDLE   = 3'd0;
    localparam t_upc P_INIT   = 3'd1;
    localparam t_upc P_DIV    = 3'd2;
    localparam t_upc P_SEL    = 3'd3;
    localparam t_upc P_WR_POS = 3'd4;
    localparam t_upc P_WR_SEL = 3'd5;
    localparam t_upc P_CLEAR  = 3'd6;
    localparam t_upc P_RESUME = 3'd7;

    // Jump to target when cond holds, else step to pc + 1 (wraps).
    typedef struct packed {
        t_uop   op;
        t_ucond cond;
        t_upc   target;
    } t_uword;

    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        case (pc)
            P_IDLE:   w = '{op: OP_ACCEPT, cond: C_NO_ITEM,  target: P_IDLE};
            P_INIT:   w = '{op: OP_INIT,   cond: C_RESTART,  target: P_CLEAR};
            P_DIV:    w = '{op: OP_DIV,    cond: C_DIV_MORE, target: P_DIV};
            P_SEL:    w = '{op: OP_SEL,    cond: C_OUT_BUSY, target: P_SEL};
            P_WR_POS: w = '{op: OP_WR_POS, cond: C_NONE,     target: P_IDLE};
            P_WR_SEL: w = '{op: OP_WR_SEL, cond: C_NOT_LAST, target: P_IDLE};
            P_CLEAR:  w = '{op: OP_CLEAR,  cond: C_CLR_MORE, target: P_CLEAR};
            // pending draw resumes at INIT; otherwise the counter wraps to IDLE
            P_RESUME: w = '{op: OP_NOP,    cond: C_PEND,     target: P_INIT};
            default:  w = '{op: OP_NOP,    cond: C_NONE,     target: P_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: src/permutation_shuffle_generator.sv
// Fisher-Yates permutation generator. Each input beat carries one random draw and
// produces one output beat: the next index of the current permutation of
// element_count entries (clamped to 1..MAX_ELEMENTS), with round_last set on the
// final index of a round. The remainder draw mod (count - position) runs in an
// iterative unit that retires 4 dividend bits per cycle, and the index table is one
// memory with a single read and a single write port, so the swap costs two reads
// and two writes; the next draw is accepted only after both writes. The draw also
// waits while an earlier result is still held by a stalled receiver. After reset,
// and after every round, a clearing pass restores the table to identity one slot
// per cycle while no draw is accepted: all MAX_ELEMENTS slots after reset, and
// after a round the slots up to the highest one touched; each pass is followed
// by a resume step before the next accept. Lowering element_count to or below
// the current position restarts the round at the next draw. Config writes are
// always taken.
module permutation_shuffle_generator import psg_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [DRAW_W-1:0]  i_random_draw,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [PICK_W-1:0]  o_picked_index,
    output logic               o_round_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [COUNT_W-1:0] i_element_count
);

    localparam int AW   = $clog2(MAX_ELEMENTS);
    localparam int DW   = $clog2(MAX_ELEMENTS + 1);
    localparam int CMPW = (DW > COUNT_W) ? DW : COUNT_W;

    t_upc               r_pc;
    t_upc               n_pc;
    t_uword             uw;
    logic               cond_true;

    logic [COUNT_W-1:0] r_count;
    logic [DRAW_W-1:0]  r_draw;
    logic               r_pend;
    logic [AW-1:0]      r_pos;
    logic [AW-1:0]      r_sel;
    logic [AW-1:0]      r_clr;
    logic [DW-1:0]      r_hi;
    logic [AW-1:0]      r_val_pos;
    logic               r_out_valid;
    logic [PICK_W-1:0]  r_picked;
    logic               r_last;

    logic [AW-1:0]      r_table [MAX_ELEMENTS];
    logic [AW-1:0]      r_rdata;
    logic               tbl_we;
    logic [AW-1:0]      tbl_waddr;
    logic [AW-1:0]      tbl_wdata;
    logic               tbl_re;
    logic [AW-1:0]      tbl_raddr;

    logic [CMPW-1:0]    count_x;
    logic [DW-1:0]      n_eff;
    logic [DW-1:0]      pos_x;
    logic [DW-1:0]      remaining;
    logic               is_last;
    logic [DW-1:0]      sel_sum;
    logic [DW-1:0]      sel_inc;
    logic [DW-1:0]      clr_inc;

    t_div_ctl           div_ctl;
    logic [DW-1:0]      div_rem;
    logic               div_more;

    // effective count, clamped to 1..MAX_ELEMENTS
    always_comb begin
        count_x = CMPW'(r_count);
        if (r_count == '0) begin
            n_eff = DW'(1);
        end else if (count_x > CMPW'(MAX_ELEMENTS)) begin
            n_eff = DW'(MAX_ELEMENTS);
        end else begin
            n_eff = DW'(count_x);
        end
    end

    assign pos_x     = DW'(r_pos);
    assign remaining = n_eff - pos_x;
    assign is_last   = (pos_x + DW'(1)) >= n_eff;
    assign sel_sum   = pos_x + div_rem;
    assign sel_inc   = DW'(r_sel) + DW'(1);
    assign clr_inc   = DW'(r_clr) + DW'(1);

    // sequencer
    assign uw = ucode(r_pc);

    always_comb begin
        case (uw.cond)
            C_NONE:     cond_true = 1'b0;
            C_NO_ITEM:  cond_true = !i_in_valid;
            C_RESTART:  cond_true = (pos_x >= n_eff);
            C_DIV_MORE: cond_true = div_more;
            C_OUT_BUSY: cond_true = r_out_valid && i_out_stall;
            C_NOT_LAST: cond_true = !is_last;
            C_CLR_MORE: cond_true = (clr_inc < r_hi);
            C_PEND:     cond_true = r_pend;
            default:    cond_true = 1'b0;
        endcase
    end

    assign n_pc = cond_true ? uw.target : r_pc + t_upc'(1);

    // table port selection
    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = r_pos;
        tbl_wdata = r_rdata;
        tbl_re    = 1'b0;
        tbl_raddr = r_pos;
        case (uw.op)
            OP_INIT: begin
                tbl_re = 1'b1;
            end
            OP_SEL: begin
                tbl_re    = 1'b1;
                tbl_raddr = AW'(sel_sum);
            end
            OP_WR_POS: begin
                tbl_we = 1'b1;
            end
            OP_WR_SEL: begin
                tbl_we    = 1'b1;
                tbl_waddr = r_sel;
                tbl_wdata = r_val_pos;
            end
            OP_CLEAR: begin
                tbl_we    = 1'b1;
                tbl_waddr = r_clr;
                tbl_wdata = r_clr;
            end
            default: begin
                tbl_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_table[tbl_waddr] <= tbl_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_re) begin
            r_rdata <= r_table[tbl_raddr];
        end
    end

    assign div_ctl.start = (uw.op == OP_INIT);
    assign div_ctl.step  = (uw.op == OP_DIV);

    psg_remdiv #(
        .DVS_W (DW)
    ) u_remdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (DIVD_W'(r_draw)),
        .i_divisor  (remaining),
        .o_rem      (div_rem),
        .o_more     (div_more)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= P_CLEAR;
            r_count     <= COUNT_RESET;
            r_pend      <= 1'b0;
            r_pos       <= '0;
            r_clr       <= '0;
            r_hi        <= DW'(MAX_ELEMENTS);
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (i_cfg_valid) begin
                r_count <= i_element_count;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (uw.op)
                OP_ACCEPT: begin
                    if (i_in_valid) begin
                        r_pend <= 1'b1;
                    end
                end
                OP_SEL: begin
                    r_pend <= 1'b0;
                end
                OP_WR_POS: begin
                    r_out_valid <= 1'b1;
                end
                OP_WR_SEL: begin
                    if (!is_last) begin
                        r_pos <= r_pos + AW'(1);
                    end
                    if (sel_inc > r_hi) begin
                        r_hi <= sel_inc;
                    end
                end
                OP_CLEAR: begin
                    if (clr_inc < r_hi) begin
                        r_clr <= r_clr + AW'(1);
                    end else begin
                        r_clr <= '0;
                        r_hi  <= '0;
                        r_pos <= '0;
                    end
                end
                default: begin
                    r_pend <= r_pend;
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (uw.op)
            OP_ACCEPT: begin
                if (i_in_valid) begin
                    r_draw <= i_random_draw;
                end
            end
            OP_DIV: begin
                r_val_pos <= r_rdata;
            end
            OP_SEL: begin
                r_sel <= AW'(sel_sum);
            end
            OP_WR_POS: begin
                r_picked <= PICK_W'(r_rdata);
                r_last   <= is_last;
            end
            default: begin
                r_sel <= r_sel;
            end
        endcase
    end

    assign o_in_stall     = (r_pc != P_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_picked_index = r_picked;
    assign o_round_last   = r_last;

    a_accept_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_pend)
        else $error("accepted draw not marked pending");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == P_WR_POS) |-> !r_out_valid)
        else $error("result written over an untaken beat");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == P_SEL) |-> (div_rem < remaining))
        else $error("remainder not below divisor");

    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == P_WR_SEL) |-> ((r_sel >= r_pos) && (DW'(r_sel) < n_eff)))
        else $error("selected slot out of range");

    a_clear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == P_CLEAR) |-> (DW'(r_clr) < r_hi))
        else $error("clearing pass beyond touched slots");

endmodule

FILE: src/psg_remdiv.sv
module psg_remdiv import psg_pkg::*; #(
    parameter int DVS_W = $clog2(MAX_ELEMENTS_DEF + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_ctl          i_ctl,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0]  i_divisor,
    output logic [DVS_W-1:0]  o_rem,
    output logic              o_more
);

    localparam int SC_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    logic [DIVD_W-1:0] r_dvd;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W-1:0]  r_rem;
    logic [SC_W-1:0]   r_cnt;
    logic [DVS_W-1:0]  n_rem;
    logic [DVS_W:0]    trial;

    // restoring remainder, DIV_BITS dividend bits per cycle
    always_comb begin
        n_rem = r_rem;
        trial = '0;
        for (int b = 0; b < DIV_BITS; b++) begin
            trial = {n_rem, r_dvd[DIVD_W-1-b]};
            if (trial >= {1'b0, r_dvs}) begin
                trial = trial - {1'b0, r_dvs};
            end
            n_rem = trial[DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (i_ctl.step) begin
            r_dvd <= r_dvd << DIV_BITS;
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.start) begin
            r_cnt <= '0;
        end else if (i_ctl.step) begin
            r_cnt <= r_cnt + SC_W'(1);
        end
    end

    assign o_rem  = r_rem;
    assign o_more = (r_cnt != SC_W'(DIV_STEPS - 1));

endmodule

FILE: sim/tb_top.sv
module tb_top import psg_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = MAX_ELEMENTS_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam logic [DRAW_W-1:0] DRAW_MAX = {DRAW_W{1'b1}};

    typedef struct packed {
        logic [PICK_W-1:0] index;
        logic              last;
    } t_pick;

    // Shuffle predictor plus queue of expected picks
    class shuffle_scoreboard;
        logic [PICK_W-1:0]  slot_map[SLOTS];
        int unsigned        pos;
        logic [COUNT_W-1:0] count_reg;
        t_pick              expected_picks[$];
        int                 errors;

        function new();
            count_reg = COUNT_RESET;
            errors    = 0;
            restart_round();
        endfunction

        function void restart_round();
            for (int k = 0; k < SLOTS; k++) begin
                slot_map[k] = PICK_W'(k);
            end
            pos = 0;
        endfunction

        function void set_count(logic [COUNT_W-1:0] value);
            count_reg = value;
        endfunction

        function int unsigned live_count();
            int unsigned n;
            n = count_reg;
            if (n < 1) n = 1;
            if (n > SLOTS) n = SLOTS;
            return n;
        endfunction

        function void note_draw(logic [DRAW_W-1:0] draw);
            int unsigned n;
            int unsigned sel;
            logic [PICK_W-1:0] held;
            t_pick p;
            n = live_count();
            // count lowered to or below the position: start over
            if (pos >= n) restart_round();
            sel = pos + (int'(draw) % (n - pos));
            if (sel >= SLOTS) sel = SLOTS - 1;
            p.index        = slot_map[sel];
            held           = slot_map[pos];
            slot_map[pos]  = p.index;
            slot_map[sel]  = held;
            if (pos + 1 >= n) begin
                p.last = 1'b1;
                restart_round();
            end else begin
                p.last = 1'b0;
                pos++;
            end
            expected_picks.insert(expected_picks.size(), p);
        endfunction

        function void check_pick(logic [PICK_W-1:0] index, logic last);
            t_pick want;
            if (expected_picks.size() == 0) begin
                $display("%0t: unexpected pick index=%0d last=%0b", $time, index, last);
                errors++;
                return;
            end
            want = expected_picks.pop_front();
            if (index !== want.index) begin
                $display("%0t: picked_index expected %0d actual %0d",
                         $time, want.index, index);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: round_last expected %0b actual %0b",
                         $time, want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_picks.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [DRAW_W-1:0]  i_random_draw;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [PICK_W-1:0]  o_picked_index;
    logic               o_round_last;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [COUNT_W-1:0] i_element_count;

    shuffle_scoreboard sb;
    int unsigned       send_idle_pct;
    int unsigned       recv_stall_pct;
    int                quiet_cycles;

    permutation_shuffle_generator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_random_draw   (i_random_draw),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_picked_index  (o_picked_index),
        .o_round_last    (o_round_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_element_count (i_element_count)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    // Receiver: random stall, decided at the falling edge
    always @(negedge i_clk) begin
        i_out_stall = ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_pick(o_picked_index, o_round_last);
        end
    end

    // Watchdog: only counts while something is outstanding
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else if (i_in_valid || i_cfg_valid || sb.pending() != 0) begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[permutation_shuffle_generator] ERROR");
                $finish;
            end
        end
    end

    task automatic send_draw(input logic [DRAW_W-1:0] draw);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_random_draw = draw;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_draw(draw);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Only called with the block drained
    task automatic write_count(input logic [COUNT_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_valid     = 1'b1;
        i_element_count = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_count(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [DRAW_W-1:0] rand_draw();
        case ($urandom_range(9))
            0:       return DRAW_MAX;
            1, 2:    return DRAW_W'($urandom_range(130));
            default: return DRAW_W'($urandom);
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] rand_count();
        case ($urandom_range(11))
            0:       return '0;
            1:       return 7'd1;
            2:       return 7'd2;
            3:       return 7'd64;
            4:       return 7'd127;
            5:       return COUNT_W'($urandom_range(127));
            default: return COUNT_W'($urandom_range(3, 20));
        endcase
    endfunction

    initial begin
        sb              = new();
        quiet_cycles    = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_random_draw   = '0;
        i_out_stall     = 1'b0;
        i_cfg_valid     = 1'b0;
        i_element_count = COUNT_RESET;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset count first, field extremes
        send_draw('0);
        send_draw(DRAW_MAX);
        send_draw(31'd1);
        send_draw(31'h5555_5555);
        send_draw(31'h2AAA_AAAA);
        send_draw(31'd63);
        send_draw(31'd64);
        // lowered below current position -> restart on next beat
        write_count(7'd3);
        send_draw(31'd7);
        send_draw(31'd0);
        send_draw(DRAW_MAX);
        write_count(7'd1);
        send_draw(31'd0);
        send_draw(DRAW_MAX);
        // zero count behaves as one
        write_count(7'd0);
        send_draw(31'd5);
        send_draw(DRAW_MAX);
        // above capacity clamps to 64
        write_count(7'd127);
        send_draw(31'd3);
        send_draw(31'd100);
        send_draw(DRAW_MAX);
        write_count(7'd2);
        send_draw(31'd9);
        send_draw(31'd8);
        write_count(7'd64);
        send_draw(31'd1);

        // Random: no idling, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++) begin
            int sent;
            sent = 0;
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            while (sent < 110) begin
                int seg_len;
                write_count(rand_count());
                seg_len = $urandom_range(8, 40);
                repeat (seg_len) begin
                    send_draw(rand_draw());
                end
                sent += seg_len;
            end
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[permutation_shuffle_generator] OK");
        end else begin
            $display("[permutation_shuffle_generator] ERROR");
        end
        $finish;
    end

endmodule
